// File: src/eafd_pkg.sv
// ----------------------------------------------------------------------------
// eafd_pkg
// Shared widths, reset values, register codes and types for the EEG ADC
// frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package eafd_pkg;

  // Payload widths.
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 24;
  localparam int PARTIAL_W  = 16;
  localparam int CHIP_IDX_W = 2;
  localparam int CHAN_IDX_W = 4;
  localparam int VOLT_W     = 29;
  localparam int COEF_W     = 24;
  localparam int CHIPS_W    = 2;
  localparam int BIW_W      = 2;

  // Product of a signed 24-bit sample and an unsigned 24-bit coefficient.
  localparam int PROD_W     = WORD_W + COEF_W + 1;
  localparam int FRAC_W     = 16;
  localparam int SCALED_W   = PROD_W - FRAC_W;

  // Default chain geometry.
  localparam int MAX_CHAIN_DEF      = 3;
  localparam int WORDS_PER_CHIP_DEF = 9;

  // Configuration register reset values.
  localparam logic [CHIPS_W-1:0] CHIP_COUNT_RST = 2'd1;
  localparam logic [COEF_W-1:0]  VOLT_COEF_RST  = 24'd1464842;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_COUNT = 1'b0,
    CFG_VOLT_COEF  = 1'b1
  } cfg_reg_t;

  // One assembled word with its position in the frame.
  typedef struct packed {
    logic [CHIP_IDX_W-1:0] chip;
    logic [CHAN_IDX_W-1:0] chan;
    logic                  is_status;
    logic                  last;
    logic [WORD_W-1:0]     word;
  } word_info_t;

endpackage

`default_nettype wire

// File: src/eafd_if.sv
// ----------------------------------------------------------------------------
// eafd_in_if / eafd_out_if
// Valid/ready channels for the received bytes and the decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

interface eafd_in_if;
  logic                         valid;
  logic                         ready;
  logic [eafd_pkg::BYTE_W-1:0]  rx_byte;
  logic                         frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface eafd_out_if;
  logic                                valid;
  logic                                ready;
  logic [eafd_pkg::CHIP_IDX_W-1:0]     chip_index;
  logic [eafd_pkg::CHAN_IDX_W-1:0]     channel_index;
  logic                                is_status;
  logic [eafd_pkg::WORD_W-1:0]         raw_word;
  logic signed [eafd_pkg::WORD_W-1:0]  sample_value;
  logic signed [eafd_pkg::VOLT_W-1:0]  voltage_nv;
  logic                                last_of_frame;

  modport source (output valid, chip_index, channel_index, is_status, raw_word,
                  sample_value, voltage_nv, last_of_frame, input ready);
  modport sink   (input valid, chip_index, channel_index, is_status, raw_word,
                  sample_value, voltage_nv, last_of_frame, output ready);
endinterface

`default_nettype wire

// File: src/eafd_unpack.sv
// ----------------------------------------------------------------------------
// eafd_unpack
// Frame position counters and byte-to-word assembly. Each completed word is
// held in a one-entry word register together with its chip and channel index.
// ----------------------------------------------------------------------------
`default_nettype none

module eafd_unpack #(
  parameter int MAX_CHAIN      = eafd_pkg::MAX_CHAIN_DEF,
  parameter int WORDS_PER_CHIP = eafd_pkg::WORDS_PER_CHIP_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          byte_valid,
  output      logic                          byte_ready,
  input  wire logic [eafd_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic                          frame_start,
  input  wire logic [eafd_pkg::CHIPS_W-1:0]  chip_count,
  output      logic                          word_valid,
  input  wire logic                          word_ready,
  output      eafd_pkg::word_info_t          word_info
);

  logic                               header_pending_r, header_pending_nxt;
  logic [eafd_pkg::BIW_W-1:0]         byte_in_word_r, byte_in_word_nxt;
  logic [eafd_pkg::CHAN_IDX_W-1:0]    word_in_chip_r, word_in_chip_nxt;
  logic [eafd_pkg::CHIP_IDX_W-1:0]    chip_counter_r, chip_counter_nxt;
  logic [eafd_pkg::PARTIAL_W-1:0]     partial_r, partial_nxt;
  logic                               word_valid_r, word_valid_nxt;
  eafd_pkg::word_info_t               word_info_r, word_info_nxt;

  logic                               byte_fire;
  logic                               word_done;
  logic [eafd_pkg::CHIPS_W-1:0]       chips;
  logic                               last_chip;
  logic                               last_word;

  // A new byte is taken whenever the word register is free or drains now.
  assign byte_ready = !word_valid_r || word_ready;
  assign byte_fire  = byte_valid && byte_ready;

  // Active chain length: zero counts as one, clamp to the chain limit.
  always_comb begin
    chips = chip_count;
    if (chip_count == '0) begin
      chips = 2'd1;
    end else if (int'(chip_count) > MAX_CHAIN) begin
      chips = eafd_pkg::CHIPS_W'(MAX_CHAIN);
    end
  end

  assign last_chip = ({1'b0, chip_counter_r} + 3'd1) >= {1'b0, chips};
  assign last_word = ({1'b0, word_in_chip_r} + 5'd1) >= 5'(WORDS_PER_CHIP);

  // Counter and word assembly update for each transferred byte.
  always_comb begin
    header_pending_nxt = header_pending_r;
    byte_in_word_nxt   = byte_in_word_r;
    word_in_chip_nxt   = word_in_chip_r;
    chip_counter_nxt   = chip_counter_r;
    partial_nxt        = partial_r;
    word_done          = 1'b0;
    word_info_nxt      = word_info_r;

    if (byte_fire) begin
      if (frame_start || header_pending_r) begin
        // Dummy command echo byte: resynchronize to the frame start.
        header_pending_nxt = 1'b0;
        byte_in_word_nxt   = '0;
        word_in_chip_nxt   = '0;
        chip_counter_nxt   = '0;
        partial_nxt        = '0;
      end else if (byte_in_word_r < 2'd2) begin
        partial_nxt      = {partial_r[eafd_pkg::BYTE_W-1:0], rx_byte};
        byte_in_word_nxt = byte_in_word_r + 2'd1;
      end else begin
        // Third byte completes the word.
        word_done               = 1'b1;
        word_info_nxt.chip      = chip_counter_r;
        word_info_nxt.chan      = word_in_chip_r;
        word_info_nxt.is_status = (word_in_chip_r == '0);
        word_info_nxt.last      = last_chip && last_word;
        word_info_nxt.word      = {partial_r, rx_byte};
        byte_in_word_nxt        = '0;
        partial_nxt             = '0;
        if (last_chip && last_word) begin
          header_pending_nxt = 1'b1;
          word_in_chip_nxt   = '0;
          chip_counter_nxt   = '0;
        end else if (last_word) begin
          word_in_chip_nxt = '0;
          chip_counter_nxt = chip_counter_r + 2'd1;
        end else begin
          word_in_chip_nxt = word_in_chip_r + 4'd1;
        end
      end
    end
  end

  // Word register occupancy.
  always_comb begin
    word_valid_nxt = word_valid_r;
    if (word_done) begin
      word_valid_nxt = 1'b1;
    end else if (word_ready) begin
      word_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pending_r <= 1'b1;
      byte_in_word_r   <= '0;
      word_in_chip_r   <= '0;
      chip_counter_r   <= '0;
      partial_r        <= '0;
      word_valid_r     <= 1'b0;
    end else begin
      header_pending_r <= header_pending_nxt;
      byte_in_word_r   <= byte_in_word_nxt;
      word_in_chip_r   <= word_in_chip_nxt;
      chip_counter_r   <= chip_counter_nxt;
      partial_r        <= partial_nxt;
      word_valid_r     <= word_valid_nxt;
    end
  end

  // Word payload.
  always_ff @(posedge clk) begin
    word_info_r <= word_info_nxt;
  end

  assign word_valid = word_valid_r;
  assign word_info  = word_info_r;

endmodule

`default_nettype wire

// File: src/eeg_adc_frame_deframer.sv
// ----------------------------------------------------------------------------
// eeg_adc_frame_deframer
// Unpacks daisy-chained 24-bit EEG converter frames into status words and
// scaled channel samples.
// ----------------------------------------------------------------------------
// The block takes one SPI byte per clock on in_ch and never stalls a
// steady byte stream while out_ch is ready. A frame is one dummy byte
// (flagged by frame_start, or implied after reset and after the last word of
// a frame), then per chip a status word and sample words of three bytes each,
// MSB first. A word completed by its third byte is held in the word assembly
// register until the output register takes it, with the sample multiplied
// by volt_coef, shifted right by 16 and saturated to 29 bits; the output
// register then offers the result on out_ch. Configuration writes on the
// cfg_ port take effect at once and belong to idle periods only.
`default_nettype none

module eeg_adc_frame_deframer #(
  parameter int MAX_CHAIN      = eafd_pkg::MAX_CHAIN_DEF,
  parameter int WORDS_PER_CHIP = eafd_pkg::WORDS_PER_CHIP_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  eafd_in_if.sink                              in_ch,
  eafd_out_if.source                           out_ch,
  input  wire logic                            cfg_wr_en,
  input  wire logic [eafd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [eafd_pkg::COEF_W-1:0]     cfg_wdata
);

  localparam logic signed [eafd_pkg::SCALED_W-1:0] V_MAX =
    eafd_pkg::SCALED_W'(268435455);
  localparam logic signed [eafd_pkg::SCALED_W-1:0] V_MIN =
    -eafd_pkg::SCALED_W'(268435456);

  logic [eafd_pkg::CHIPS_W-1:0]           chip_count_r;
  logic [eafd_pkg::COEF_W-1:0]            volt_coef_r;

  logic                                   word_valid;
  logic                                   word_ready;
  eafd_pkg::word_info_t                   word_info;

  logic                                   out_valid_r, out_valid_nxt;
  logic [eafd_pkg::CHIP_IDX_W-1:0]        chip_index_r;
  logic [eafd_pkg::CHAN_IDX_W-1:0]        channel_index_r;
  logic                                   is_status_r;
  logic [eafd_pkg::WORD_W-1:0]            raw_word_r;
  logic signed [eafd_pkg::WORD_W-1:0]     sample_value_r, sample_nxt;
  logic signed [eafd_pkg::VOLT_W-1:0]     voltage_nv_r, voltage_nxt;
  logic                                   last_of_frame_r;

  logic signed [eafd_pkg::PROD_W-1:0]     product;
  logic signed [eafd_pkg::SCALED_W-1:0]   scaled;
  logic                                   out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_count_r <= eafd_pkg::CHIP_COUNT_RST;
      volt_coef_r  <= eafd_pkg::VOLT_COEF_RST;
    end else if (cfg_wr_en) begin
      case (eafd_pkg::cfg_reg_t'(cfg_index))
        eafd_pkg::CFG_CHIP_COUNT: chip_count_r <= cfg_wdata[eafd_pkg::CHIPS_W-1:0];
        eafd_pkg::CFG_VOLT_COEF:  volt_coef_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte counting and word assembly.
  eafd_unpack #(
    .MAX_CHAIN      (MAX_CHAIN),
    .WORDS_PER_CHIP (WORDS_PER_CHIP)
  ) u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_ch.valid),
    .byte_ready  (in_ch.ready),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .chip_count  (chip_count_r),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word_info   (word_info)
  );

  // The output register loads when empty or when its result is transferred.
  assign out_load   = !out_valid_r || out_ch.ready;
  assign word_ready = out_load;

  // Sign extension and nanovolt scaling with an arithmetic shift.
  assign sample_nxt = word_info.is_status ? '0 : $signed(word_info.word);
  assign product    = sample_nxt * $signed({1'b0, volt_coef_r});
  assign scaled     = product[eafd_pkg::PROD_W-1:eafd_pkg::FRAC_W];

  // Saturate to the 29-bit signed result range.
  always_comb begin
    if (scaled > V_MAX) begin
      voltage_nxt = V_MAX[eafd_pkg::VOLT_W-1:0];
    end else if (scaled < V_MIN) begin
      voltage_nxt = V_MIN[eafd_pkg::VOLT_W-1:0];
    end else begin
      voltage_nxt = scaled[eafd_pkg::VOLT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load && word_valid) begin
      chip_index_r    <= word_info.chip;
      channel_index_r <= word_info.chan;
      is_status_r     <= word_info.is_status;
      raw_word_r      <= word_info.word;
      sample_value_r  <= sample_nxt;
      voltage_nv_r    <= voltage_nxt;
      last_of_frame_r <= word_info.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chip_index    = chip_index_r;
  assign out_ch.channel_index = channel_index_r;
  assign out_ch.is_status     = is_status_r;
  assign out_ch.raw_word      = raw_word_r;
  assign out_ch.sample_value  = sample_value_r;
  assign out_ch.voltage_nv    = voltage_nv_r;
  assign out_ch.last_of_frame = last_of_frame_r;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the EEG ADC frame deframer.
// ----------------------------------------------------------------------------
// A queue of SPI bytes feeds a valid/ready driver. Each byte transfer runs
// through a cycle-free model of the deframer, and every word it completes
// is queued as an expected result. A monitor drains the result channel and
// compares every field against the oldest expected word. The run goes
// through eight phases with different chain lengths, voltage coefficients
// and idle patterns on both channels. The registers are rewritten only
// while nothing is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 8;
  localparam int BYTES_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 6;
  localparam logic [eafd_pkg::COEF_W-1:0] COEF_MAX = '1;
  localparam longint VOLT_MAX = 268435455;
  localparam longint VOLT_MIN = -268435456;

  // Chain length written at the start of each phase.
  localparam logic [eafd_pkg::CHIPS_W-1:0] CHIP_TAB [PHASES] =
    '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};

  // One byte as it leaves the SPI receiver.
  typedef struct packed {
    logic [eafd_pkg::BYTE_W-1:0] rx_byte;
    logic                        frame_start;
  } spi_byte_t;

  // One decoded word as the deframer should present it.
  typedef struct packed {
    logic [eafd_pkg::CHIP_IDX_W-1:0]    chip;
    logic [eafd_pkg::CHAN_IDX_W-1:0]    chan;
    logic                               status;
    logic [eafd_pkg::WORD_W-1:0]        raw;
    logic signed [eafd_pkg::WORD_W-1:0] sample;
    logic signed [eafd_pkg::VOLT_W-1:0] volts;
    logic                               last;
  } word_result_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  eafd_pkg::cfg_reg_t            cfg_index = eafd_pkg::CFG_CHIP_COUNT;
  logic [eafd_pkg::COEF_W-1:0]   cfg_wdata = '0;

  eafd_in_if  in_ch ();
  eafd_out_if out_ch ();

  eeg_adc_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be driven and words waiting to come out.
  spi_byte_t    spi_byte_q[$];
  word_result_t word_q[$];
  int           err_count    = 0;
  int           queued_bytes = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;

  // Shadow copies of the configuration registers.
  logic [eafd_pkg::CHIPS_W-1:0] chips_cfg = eafd_pkg::CHIP_COUNT_RST;
  logic [eafd_pkg::COEF_W-1:0]  coef_cfg  = eafd_pkg::VOLT_COEF_RST;

  // Deframer state as the model tracks it.
  logic                            hdr_pending = 1'b1;
  logic [eafd_pkg::BIW_W-1:0]      byte_cnt    = '0;
  logic [eafd_pkg::CHAN_IDX_W-1:0] word_cnt    = '0;
  logic [eafd_pkg::CHIP_IDX_W-1:0] chip_cnt    = '0;
  logic [eafd_pkg::PARTIAL_W-1:0]  partial     = '0;

  // Clock generation.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Chip count as the block uses it: zero means one, large values clamp.
  function automatic int active_chips(input logic [eafd_pkg::CHIPS_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (int'(cnt) > eafd_pkg::MAX_CHAIN_DEF) return eafd_pkg::MAX_CHAIN_DEF;
    return int'(cnt);
  endfunction

  // Advances the deframer model by one byte; returns 1 when a word completes.
  function automatic bit deframe_byte(input logic [eafd_pkg::BYTE_W-1:0] b,
                                      input logic start,
                                      output word_result_t res);
    logic [eafd_pkg::WORD_W-1:0] word;
    longint                      s;
    longint                      q;
    bit                          last;
    res = '0;
    if (start || hdr_pending) begin
      hdr_pending = 1'b0;
      byte_cnt    = '0;
      word_cnt    = '0;
      chip_cnt    = '0;
      partial     = '0;
      return 1'b0;
    end
    if (byte_cnt < 2) begin
      partial  = {partial[eafd_pkg::BYTE_W-1:0], b};
      byte_cnt = byte_cnt + 1'b1;
      return 1'b0;
    end
    word     = {partial, b};
    byte_cnt = '0;
    partial  = '0;

    res.chip   = chip_cnt;
    res.chan   = word_cnt;
    res.status = (word_cnt == 0);
    res.raw    = word;
    if (!res.status) begin
      s = longint'($signed(word));
      q = (s * longint'(coef_cfg)) >>> eafd_pkg::FRAC_W;
      if (q > VOLT_MAX) q = VOLT_MAX;
      if (q < VOLT_MIN) q = VOLT_MIN;
      res.sample = word;
      res.volts  = q[eafd_pkg::VOLT_W-1:0];
    end
    last = (int'(chip_cnt) + 1 >= active_chips(chips_cfg)) &&
           (int'(word_cnt) + 1 >= eafd_pkg::WORDS_PER_CHIP_DEF);
    res.last = last;

    if (last) begin
      hdr_pending = 1'b1;
      word_cnt    = '0;
      chip_cnt    = '0;
    end else if (int'(word_cnt) + 1 >= eafd_pkg::WORDS_PER_CHIP_DEF) begin
      word_cnt = '0;
      chip_cnt = chip_cnt + 1'b1;
    end else begin
      word_cnt = word_cnt + 1'b1;
    end
    return 1'b1;
  endfunction

  // Flags one field that differs from the expected word.
  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Driver: predicts each transferred byte, then offers the next one.
  always @(posedge clk) begin
    word_result_t res;
    spi_byte_t    nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.rx_byte, in_ch.frame_start, res)) word_q.push_back(res);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // The byte on the bus has to stay until it is taken.
      end else if (spi_byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = spi_byte_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= nxt.rx_byte;
        in_ch.frame_start <= nxt.frame_start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each word transfer with the oldest expected word.
  always @(posedge clk) begin
    word_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (word_q.size() == 0) begin
          $error("word with nothing expected: chip %0d channel %0d raw %06h",
                 out_ch.chip_index, out_ch.channel_index, out_ch.raw_word);
          err_count++;
        end else begin
          want = word_q.pop_front();
          check_field("chip_index", want.chip, out_ch.chip_index);
          check_field("channel_index", want.chan, out_ch.channel_index);
          check_field("is_status", want.status, out_ch.is_status);
          check_field("raw_word", want.raw, out_ch.raw_word);
          check_field("sample_value", $signed(want.sample), $signed(out_ch.sample_value));
          check_field("voltage_nv", $signed(want.volts), $signed(out_ch.voltage_nv));
          check_field("last_of_frame", want.last, out_ch.last_of_frame);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Bytes lean toward the sign and saturation corners of the samples.
  function automatic logic [eafd_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return eafd_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [eafd_pkg::BYTE_W-1:0] b, input logic start);
    spi_byte_q.push_back('{rx_byte: b, frame_start: start});
    queued_bytes++;
  endtask

  // A dummy byte and then all words of the chain, or a random cut of them.
  task automatic push_frame(input bit broken);
    int len;
    len = active_chips(chips_cfg) * eafd_pkg::WORDS_PER_CHIP_DEF * 3;
    if (broken) len = $urandom_range(1, len - 1);
    push_byte(pick_byte(), $urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) push_byte(pick_byte(), 1'b0);
  endtask

  // Waits until every byte is taken and every word has come out.
  task automatic wait_drained();
    @(negedge clk);
    while (spi_byte_q.size() != 0 || in_ch.valid || word_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One write on the configuration port, mirrored in the shadow copies.
  task automatic cfg_write(input eafd_pkg::cfg_reg_t idx,
                           input logic [eafd_pkg::COEF_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == eafd_pkg::CFG_CHIP_COUNT) chips_cfg = val[eafd_pkg::CHIPS_W-1:0];
    else coef_cfg = val;
  endtask

  // Known levels on every input before the first edge.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // Main sequence: reset, then the phases, then the final verdict.
  initial begin
    logic [eafd_pkg::COEF_W-1:0] coef;
    int                          phase_end;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0, 4:    coef = COEF_MAX;
        1, 5:    coef = eafd_pkg::VOLT_COEF_RST;
        2:       coef = '0;
        7:       coef = 24'd1;
        default: coef = eafd_pkg::COEF_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      cfg_write(eafd_pkg::CFG_CHIP_COUNT, eafd_pkg::COEF_W'(CHIP_TAB[p]));
      cfg_write(eafd_pkg::CFG_VOLT_COEF, coef);

      @(negedge clk);
      case (p / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase

      // Directed opening: implied dummy, resync in mid-word, sample corners.
      if (p == 0) begin
        push_byte(8'hA5, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
      end

      // Mostly whole frames, with stray bytes and cut frames mixed in.
      phase_end = queued_bytes + BYTES_PER_PHASE;
      while (queued_bytes < phase_end) begin
        case ($urandom_range(0, 9))
          0:       push_byte(pick_byte(), $urandom_range(0, 1));
          1:       push_frame(1'b1);
          default: push_frame(1'b0);
        endcase
      end
    end

    wait_drained();
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_600_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// File: eeg_adc_frame_deframer.f
src/eafd_pkg.sv
src/eafd_if.sv
src/eafd_unpack.sv
src/eeg_adc_frame_deframer.sv
dv/tb_top.sv
